// ===== rtl/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// bps_pkg
// shared types, widths, register map and reset values of the protection
// supervisor
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int CODE_W     = 12;
  localparam int MV_W       = 12;
  localparam int REF_W      = 14;
  localparam int VCNT_W     = 8;
  localparam int ICNT_W     = 11;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 24;

  // pin millivolts per full-scale code
  localparam logic [CODE_W-1:0] ADC_FULL_MV = 12'd3300;

  // consecutive-sample limits
  localparam logic [VCNT_W-1:0] VOUT_OVER_LIMIT = 8'd200;
  localparam logic [ICNT_W-1:0] IOUT_OVER_LIMIT = 11'd2000;

  // reset values of the configuration registers
  localparam logic [MV_W-1:0]  RST_VIN_OVER    = 12'd2182;
  localparam logic [MV_W-1:0]  RST_VIN_UNDER   = 12'd727;
  localparam logic [MV_W-1:0]  RST_VIN_HYST    = 12'd182;
  localparam logic [MV_W-1:0]  RST_VOUT_OVER   = 12'd909;
  localparam logic [MV_W-1:0]  RST_IOUT_OVER   = 12'd2125;
  localparam logic [REF_W-1:0] RST_VOLT_TARGET = 14'd5000;
  localparam logic [REF_W-1:0] RST_CURR_TARGET = 14'd3000;

  typedef enum logic [2:0] {
    REG_VIN_OVER    = 3'd0,
    REG_VIN_UNDER   = 3'd1,
    REG_VIN_HYST    = 3'd2,
    REG_VOUT_OVER   = 3'd3,
    REG_IOUT_OVER   = 3'd4,
    REG_VOLT_TARGET = 3'd5,
    REG_CURR_TARGET = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    FAULT_NONE     = 3'd0,
    FAULT_VIN_OVER = 3'd1,
    FAULT_VIN_UNDR = 3'd2,
    FAULT_VOUT_OVR = 3'd3,
    FAULT_IOUT_OVR = 3'd4
  } fault_t;

  typedef struct packed {
    logic [MV_W-1:0]  vin_over_mv;
    logic [MV_W-1:0]  vin_under_mv;
    logic [MV_W-1:0]  vin_hysteresis_mv;
    logic [MV_W-1:0]  vout_over_mv;
    logic [MV_W-1:0]  iout_over_mv;
    logic [REF_W-1:0] voltage_target_mv;
    logic [REF_W-1:0] current_target_ma;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    logic [MV_W-1:0] vin_mv;
    logic [MV_W-1:0] vout_mv;
    logic [MV_W-1:0] iout_mv;
  } sample_mv_t;

endpackage

// ===== rtl/bps_sample_if.sv =====
// ----------------------------------------------------------------------------
// bps_sample_if
// adc sample set channel: input voltage, output voltage and output current
// ----------------------------------------------------------------------------
interface bps_sample_if;
  logic                       valid;
  logic                       ready;
  logic [bps_pkg::CODE_W-1:0] vin_code;
  logic [bps_pkg::CODE_W-1:0] vout_code;
  logic [bps_pkg::CODE_W-1:0] iout_code;

  modport source (output valid, output vin_code, output vout_code, output iout_code,
                  input ready);
  modport sink (input valid, input vin_code, input vout_code, input iout_code,
                output ready);
endinterface

// ===== rtl/bps_result_if.sv =====
// ----------------------------------------------------------------------------
// bps_result_if
// supervisor status channel, one transaction per sample set
// ----------------------------------------------------------------------------
interface bps_result_if;
  logic                      valid;
  logic                      ready;
  logic                      output_enable;
  logic [bps_pkg::REF_W-1:0] voltage_ref_mv;
  logic [bps_pkg::REF_W-1:0] current_ref_ma;
  logic [2:0]                fault_code;
  logic                      ramp_done;
  logic [1:0]                vin_fault_latched;

  modport source (output valid, output output_enable, output voltage_ref_mv,
                  output current_ref_ma, output fault_code, output ramp_done,
                  output vin_fault_latched, input ready);
  modport sink (input valid, input output_enable, input voltage_ref_mv,
                input current_ref_ma, input fault_code, input ramp_done,
                input vin_fault_latched, output ready);
endinterface

// ===== rtl/bps_regs.sv =====
// ----------------------------------------------------------------------------
// bps_regs
// apb configuration registers: thresholds and soft-start targets
// ----------------------------------------------------------------------------
module bps_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bps_pkg::ADDR_W-1:0]  paddr,
  input  logic [bps_pkg::DATA_W-1:0]  pwdata,
  output logic [bps_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bps_pkg::cfg_t               cfg
);

  bps_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = bps_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vin_over_mv       <= bps_pkg::RST_VIN_OVER;
      cfg.vin_under_mv      <= bps_pkg::RST_VIN_UNDER;
      cfg.vin_hysteresis_mv <= bps_pkg::RST_VIN_HYST;
      cfg.vout_over_mv      <= bps_pkg::RST_VOUT_OVER;
      cfg.iout_over_mv      <= bps_pkg::RST_IOUT_OVER;
      cfg.voltage_target_mv <= bps_pkg::RST_VOLT_TARGET;
      cfg.current_target_ma <= bps_pkg::RST_CURR_TARGET;
    end else if (wr_en) begin
      unique case (idx)
        bps_pkg::REG_VIN_OVER:    cfg.vin_over_mv       <= pwdata[bps_pkg::MV_W-1:0];
        bps_pkg::REG_VIN_UNDER:   cfg.vin_under_mv      <= pwdata[bps_pkg::MV_W-1:0];
        bps_pkg::REG_VIN_HYST:    cfg.vin_hysteresis_mv <= pwdata[bps_pkg::MV_W-1:0];
        bps_pkg::REG_VOUT_OVER:   cfg.vout_over_mv      <= pwdata[bps_pkg::MV_W-1:0];
        bps_pkg::REG_IOUT_OVER:   cfg.iout_over_mv      <= pwdata[bps_pkg::MV_W-1:0];
        bps_pkg::REG_VOLT_TARGET: cfg.voltage_target_mv <= pwdata[bps_pkg::REF_W-1:0];
        bps_pkg::REG_CURR_TARGET: cfg.current_target_ma <= pwdata[bps_pkg::REF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      bps_pkg::REG_VIN_OVER:    prdata = DATA_EXT12(cfg.vin_over_mv);
      bps_pkg::REG_VIN_UNDER:   prdata = DATA_EXT12(cfg.vin_under_mv);
      bps_pkg::REG_VIN_HYST:    prdata = DATA_EXT12(cfg.vin_hysteresis_mv);
      bps_pkg::REG_VOUT_OVER:   prdata = DATA_EXT12(cfg.vout_over_mv);
      bps_pkg::REG_IOUT_OVER:   prdata = DATA_EXT12(cfg.iout_over_mv);
      bps_pkg::REG_VOLT_TARGET: prdata = DATA_EXT14(cfg.voltage_target_mv);
      bps_pkg::REG_CURR_TARGET: prdata = DATA_EXT14(cfg.current_target_ma);
      default:                  prdata = '0;
    endcase
  end

  function automatic logic [bps_pkg::DATA_W-1:0] DATA_EXT12(
      input logic [bps_pkg::MV_W-1:0] v);
    return {{(bps_pkg::DATA_W-bps_pkg::MV_W){1'b0}}, v};
  endfunction

  function automatic logic [bps_pkg::DATA_W-1:0] DATA_EXT14(
      input logic [bps_pkg::REF_W-1:0] v);
    return {{(bps_pkg::DATA_W-bps_pkg::REF_W){1'b0}}, v};
  endfunction

endmodule

// ===== rtl/bps_sample_stage.sv =====
// ----------------------------------------------------------------------------
// bps_sample_stage
// input register: adc codes scaled to pin millivolts on the way in
// ----------------------------------------------------------------------------
module bps_sample_stage (
  input  logic                 clk,
  input  logic                 rst,
  bps_sample_if.sink           sample,
  input  logic                 advance,
  output bps_pkg::sample_mv_t  s1
);

  logic [bps_pkg::PROD_W-1:0] vin_prod;
  logic [bps_pkg::PROD_W-1:0] vout_prod;
  logic [bps_pkg::PROD_W-1:0] iout_prod;
  logic                       take;

  // (code * 3300) >> 12
  assign vin_prod  = {12'd0, sample.vin_code}  * {12'd0, bps_pkg::ADC_FULL_MV};
  assign vout_prod = {12'd0, sample.vout_code} * {12'd0, bps_pkg::ADC_FULL_MV};
  assign iout_prod = {12'd0, sample.iout_code} * {12'd0, bps_pkg::ADC_FULL_MV};

  assign sample.ready = !s1.valid || advance;
  assign take         = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (sample.ready) begin
      s1.valid <= sample.valid;
    end
    if (take) begin
      s1.vin_mv  <= vin_prod[bps_pkg::PROD_W-1:bps_pkg::PROD_W-bps_pkg::MV_W];
      s1.vout_mv <= vout_prod[bps_pkg::PROD_W-1:bps_pkg::PROD_W-bps_pkg::MV_W];
      s1.iout_mv <= iout_prod[bps_pkg::PROD_W-1:bps_pkg::PROD_W-bps_pkg::MV_W];
    end
  end

endmodule

// ===== rtl/bps_supervise.sv =====
// ----------------------------------------------------------------------------
// bps_supervise
// soft-start ramp, fault checks, protection state and result register
// ----------------------------------------------------------------------------
module bps_supervise (
  input  logic                clk,
  input  logic                rst,
  input  bps_pkg::cfg_t       cfg,
  input  bps_pkg::sample_mv_t s1,
  output logic                advance,
  bps_result_if.source        result
);

  // protection state
  logic                        over_latch;
  logic                        under_latch;
  logic [bps_pkg::VCNT_W-1:0]  vout_over_count;
  logic [bps_pkg::ICNT_W-1:0]  iout_over_count;
  logic                        started;
  logic                        ramping;
  logic [bps_pkg::REF_W-1:0]   voltage_ref;
  logic [bps_pkg::REF_W-1:0]   current_ref;

  logic                        over_latch_next;
  logic                        under_latch_next;
  logic [bps_pkg::VCNT_W-1:0]  vout_over_count_next;
  logic [bps_pkg::ICNT_W-1:0]  iout_over_count_next;
  logic                        started_next;
  logic                        ramping_next;
  logic [bps_pkg::REF_W-1:0]   voltage_ref_next;
  logic [bps_pkg::REF_W-1:0]   current_ref_next;

  logic                        take;
  logic [bps_pkg::REF_W-1:0]   vref_ramp;
  logic [bps_pkg::REF_W-1:0]   cref_ramp;
  logic                        ramping_ramp;
  logic [bps_pkg::MV_W:0]      vin_plus_hys;
  logic [bps_pkg::MV_W:0]      under_plus_hys;
  logic                        ov_fail;
  logic                        un_fail;
  logic [bps_pkg::VCNT_W-1:0]  vcnt_raw;
  logic [bps_pkg::ICNT_W-1:0]  icnt_raw;
  logic                        vo_fail;
  logic                        io_fail;
  bps_pkg::fault_t             fault;

  assign advance = !result.valid || result.ready;
  assign take    = s1.valid && advance;

  always_comb begin
    // soft start
    vref_ramp    = voltage_ref;
    cref_ramp    = current_ref;
    ramping_ramp = ramping;
    if (started && ramping) begin
      ramping_ramp = !(voltage_ref >= cfg.voltage_target_mv &&
                       current_ref >= cfg.current_target_ma);
      if (voltage_ref < cfg.voltage_target_mv) vref_ramp = voltage_ref + 1'b1;
      if (current_ref < cfg.current_target_ma) cref_ramp = current_ref + 1'b1;
    end

    // input latches, hysteresis compares widened so nothing wraps
    vin_plus_hys   = {1'b0, s1.vin_mv} + {1'b0, cfg.vin_hysteresis_mv};
    under_plus_hys = {1'b0, cfg.vin_under_mv} + {1'b0, cfg.vin_hysteresis_mv};
    ov_fail = (s1.vin_mv > cfg.vin_over_mv) ||
              (over_latch && !(vin_plus_hys < {1'b0, cfg.vin_over_mv}));
    un_fail = (s1.vin_mv < cfg.vin_under_mv) ||
              (under_latch && !({1'b0, s1.vin_mv} > under_plus_hys));

    // consecutive-sample counters
    vcnt_raw = (s1.vout_mv > cfg.vout_over_mv) ? vout_over_count + 1'b1 : '0;
    icnt_raw = (s1.iout_mv > cfg.iout_over_mv) ? iout_over_count + 1'b1 : '0;
    vo_fail  = vcnt_raw > bps_pkg::VOUT_OVER_LIMIT;
    io_fail  = icnt_raw > bps_pkg::IOUT_OVER_LIMIT;

    over_latch_next  = ov_fail;
    under_latch_next = ov_fail ? under_latch : un_fail;

    if (ov_fail)      fault = bps_pkg::FAULT_VIN_OVER;
    else if (un_fail) fault = bps_pkg::FAULT_VIN_UNDR;
    else if (vo_fail) fault = bps_pkg::FAULT_VOUT_OVR;
    else if (io_fail) fault = bps_pkg::FAULT_IOUT_OVR;
    else              fault = bps_pkg::FAULT_NONE;

    if (fault != bps_pkg::FAULT_NONE) begin
      // restart keeps only the input latches
      started_next         = 1'b0;
      ramping_next         = 1'b1;
      voltage_ref_next     = '0;
      current_ref_next     = '0;
      vout_over_count_next = '0;
      iout_over_count_next = '0;
    end else begin
      started_next         = 1'b1;
      ramping_next         = ramping_ramp;
      voltage_ref_next     = vref_ramp;
      current_ref_next     = cref_ramp;
      vout_over_count_next = vcnt_raw;
      iout_over_count_next = icnt_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      over_latch      <= 1'b0;
      under_latch     <= 1'b0;
      vout_over_count <= '0;
      iout_over_count <= '0;
      started         <= 1'b0;
      ramping         <= 1'b1;
      voltage_ref     <= '0;
      current_ref     <= '0;
      result.valid    <= 1'b0;
    end else begin
      if (take) begin
        over_latch      <= over_latch_next;
        under_latch     <= under_latch_next;
        vout_over_count <= vout_over_count_next;
        iout_over_count <= iout_over_count_next;
        started         <= started_next;
        ramping         <= ramping_next;
        voltage_ref     <= voltage_ref_next;
        current_ref     <= current_ref_next;
      end
      if (advance) result.valid <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.output_enable     <= started_next;
      result.voltage_ref_mv    <= voltage_ref_next;
      result.current_ref_ma    <= current_ref_next;
      result.fault_code        <= fault;
      result.ramp_done         <= !ramping_next;
      result.vin_fault_latched <= {under_latch_next, over_latch_next};
    end
  end

endmodule

// ===== rtl/buck_protection_supervisor.sv =====
// ----------------------------------------------------------------------------
// buck_protection_supervisor
// protection supervisor with soft start for a buck converter
// ----------------------------------------------------------------------------
// Takes one adc sample set per transaction (input voltage, output voltage,
// output current codes) and returns one status transaction for each. A new
// sample set is accepted every cycle unless the status side stalls; each
// passes through the input register (code to pin millivolts), then the
// result register (checks and state update). Input over- and undervoltage
// are latched and clear only past a hysteresis band; output overvoltage and
// overcurrent fault after a run of consecutive over-threshold samples. Any
// fault restarts the supervisor: output disabled, references and counters
// cleared, input latches kept. Once running, the voltage and current
// references rise by one per sample up to their targets. Thresholds and
// targets sit in apb registers at byte addresses 0x00 to 0x18 and should be
// written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module buck_protection_supervisor (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bps_pkg::ADDR_W-1:0]  paddr,
  input  logic [bps_pkg::DATA_W-1:0]  pwdata,
  output logic [bps_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  // sample sets in, status out
  bps_sample_if.sink                  sample,
  bps_result_if.source                result
);

  bps_pkg::cfg_t       cfg;
  bps_pkg::sample_mv_t s1;
  logic                advance;

  // register file
  bps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage one: scale codes into pin millivolts
  bps_sample_stage u_sample (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample),
    .advance (advance),
    .s1      (s1)
  );

  // stage two: ramp, checks, protection state, result register
  bps_supervise u_supervise (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .s1      (s1),
    .advance (advance),
    .result  (result)
  );

`ifndef SYNTHESIS
  // an enabled output only follows a clean pass
  a_enable_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.output_enable |-> result.fault_code == bps_pkg::FAULT_NONE)
    else $error("output enabled with a fault reported");

  // a fault always shows the restarted state
  a_fault_restart: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.fault_code != bps_pkg::FAULT_NONE |->
      !result.output_enable && result.voltage_ref_mv == '0 && result.current_ref_ma == '0)
    else $error("fault without restart of references");

  // a held overvoltage latch means this pass faulted on it
  a_over_latch: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.vin_fault_latched[0] |->
      result.fault_code == bps_pkg::FAULT_VIN_OVER)
    else $error("overvoltage latch set without overvoltage fault");

  // a held undervoltage latch means an input fault was reported
  a_under_latch: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.vin_fault_latched[1] |->
      result.fault_code == bps_pkg::FAULT_VIN_UNDR ||
      result.fault_code == bps_pkg::FAULT_VIN_OVER)
    else $error("undervoltage latch set without input fault");
`endif

endmodule

// ===== tb/tb_buck_protection_supervisor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buck_protection_supervisor
// self-checking bench for the buck protection supervisor
// ----------------------------------------------------------------------------
// Drives adc sample sets through the sample channel and checks every status
// transaction against a cycle-free model of the supervisor or a preset status.
// A short stimulus table covers the latch, hysteresis and restart corners
// first, then phases of mostly well-formed sample streams run under several
// threshold and target settings, including a long over-threshold run that
// reaches the output overvoltage fault, a long overcurrent run that keeps
// its counter climbing, and clean runs that finish the soft start. Both
// channel sides idle at random.
// ----------------------------------------------------------------------------
module tb_buck_protection_supervisor;

  // status fields of one result transaction
  typedef struct packed {
    logic                      oe;
    logic [bps_pkg::REF_W-1:0] vref;
    logic [bps_pkg::REF_W-1:0] iref;
    bps_pkg::fault_t           fault;
    logic                      ramp_done;
    logic [1:0]                latch;
  } status_t;

  // one row of the stimulus table; preset rows carry a hand-written status
  typedef struct {
    logic [bps_pkg::CODE_W-1:0] vin;
    logic [bps_pkg::CODE_W-1:0] vout;
    logic [bps_pkg::CODE_W-1:0] iout;
    bit                         preset;
    status_t                    want;
  } step_row_t;

  // per accepted sample: use the typed status or the model's
  typedef struct {
    bit      preset;
    status_t want;
  } preset_t;

  localparam status_t UNTYPED = '{1'b0, 14'd0, 14'd0, bps_pkg::FAULT_NONE, 1'b0, 2'd0};

  // nominal input code, 1611 pin mv, well inside the default window
  localparam logic [bps_pkg::CODE_W-1:0] VIN_OK = 12'd2000;

  // directed corners at reset thresholds (over 2182, under 727, hysteresis 182)
  step_row_t plan [18] = '{
    // first clean sample after reset starts the supervisor, no ramp yet
    '{VIN_OK, 12'd0, 12'd0, 1'b1,
      '{1'b1, 14'd0, 14'd0, bps_pkg::FAULT_NONE, 1'b0, 2'd0}},
    // running: both references take their first step
    '{VIN_OK, 12'd0, 12'd0, 1'b1,
      '{1'b1, 14'd1, 14'd1, bps_pkg::FAULT_NONE, 1'b0, 2'd0}},
    // full-scale input trips overvoltage and restarts
    '{12'd4095, 12'd0, 12'd0, 1'b1,
      '{1'b0, 14'd0, 14'd0, bps_pkg::FAULT_VIN_OVER, 1'b0, 2'd1}},
    // 2094 mv sits inside the hysteresis band, latch holds
    '{12'd2600, 12'd0, 12'd0, 1'b1,
      '{1'b0, 14'd0, 14'd0, bps_pkg::FAULT_VIN_OVER, 1'b0, 2'd1}},
    // below the band the latch clears and the supervisor starts again
    '{VIN_OK, 12'd0, 12'd0, 1'b1,
      '{1'b1, 14'd0, 14'd0, bps_pkg::FAULT_NONE, 1'b0, 2'd0}},
    // exactly on the overvoltage threshold is not a fault
    '{12'd2709, 12'd0, 12'd0, 1'b0, UNTYPED},
    // zero input trips undervoltage
    '{12'd0, 12'd0, 12'd0, 1'b1,
      '{1'b0, 14'd0, 14'd0, bps_pkg::FAULT_VIN_UNDR, 1'b0, 2'd2}},
    // 805 mv: above threshold but inside the band, latch holds
    '{12'd1000, 12'd0, 12'd0, 1'b1,
      '{1'b0, 14'd0, 14'd0, bps_pkg::FAULT_VIN_UNDR, 1'b0, 2'd2}},
    // exactly threshold plus hysteresis still holds, one code more clears
    '{12'd1129, 12'd0, 12'd0, 1'b0, UNTYPED},
    '{12'd1130, 12'd0, 12'd0, 1'b0, UNTYPED},
    // output over thresholds only advance the counters
    '{VIN_OK, 12'd4095, 12'd4095, 1'b0, UNTYPED},
    '{VIN_OK, 12'd4095, 12'd0, 1'b0, UNTYPED},
    '{VIN_OK, 12'd0, 12'd4095, 1'b0, UNTYPED},
    // input faults win over everything else
    '{12'd4095, 12'd4095, 12'd4095, 1'b1,
      '{1'b0, 14'd0, 14'd0, bps_pkg::FAULT_VIN_OVER, 1'b0, 2'd1}},
    // overvoltage latch clears on zero input, undervoltage latches right after
    '{12'd0, 12'd4095, 12'd4095, 1'b1,
      '{1'b0, 14'd0, 14'd0, bps_pkg::FAULT_VIN_UNDR, 1'b0, 2'd2}},
    // both latches held at once
    '{12'd4095, 12'd0, 12'd0, 1'b1,
      '{1'b0, 14'd0, 14'd0, bps_pkg::FAULT_VIN_OVER, 1'b0, 2'd3}},
    // nominal input clears both latches in one sample
    '{VIN_OK, 12'd0, 12'd0, 1'b0, UNTYPED},
    '{VIN_OK, 12'd4095, 12'd4095, 1'b0, UNTYPED}
  };

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [bps_pkg::ADDR_W-1:0] paddr;
  logic [bps_pkg::DATA_W-1:0] pwdata;
  logic [bps_pkg::DATA_W-1:0] prdata;
  logic pready;

  bps_sample_if sample_ch ();
  bps_result_if result_ch ();

  buck_protection_supervisor dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (sample_ch),
    .result  (result_ch)
  );

  // model state, mirrors the supervisor after reset
  bps_pkg::cfg_t sup_cfg = '{bps_pkg::RST_VIN_OVER, bps_pkg::RST_VIN_UNDER,
                             bps_pkg::RST_VIN_HYST, bps_pkg::RST_VOUT_OVER,
                             bps_pkg::RST_IOUT_OVER, bps_pkg::RST_VOLT_TARGET,
                             bps_pkg::RST_CURR_TARGET};
  bit ov_latched = 1'b0;
  bit uv_latched = 1'b0;
  bit running = 1'b0;
  bit soft_starting = 1'b1;
  int vout_run = 0;
  int iout_run = 0;
  int vref_now = 0;
  int iref_now = 0;

  status_t status_q [$];   // statuses still owed by the supervisor
  preset_t preset_q [$];   // one entry per sample set handed to the channel
  int mismatches = 0;

  // idling off for a whole phase on either side
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  // ---------------------------------------------------------------------------
  // clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // far beyond the slowest legal run (about 1250 transactions, all stalls)
  initial begin
    #(10_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // model of the supervisor
  // ---------------------------------------------------------------------------
  function automatic int pin_mv(logic [bps_pkg::CODE_W-1:0] code);
    return (int'(code) * int'(bps_pkg::ADC_FULL_MV)) >>> 12;
  endfunction

  // one sample set through the supervisor: ramp, checks, restart or run
  function automatic status_t supervise_sample(logic [bps_pkg::CODE_W-1:0] vin_c,
                                               logic [bps_pkg::CODE_W-1:0] vout_c,
                                               logic [bps_pkg::CODE_W-1:0] iout_c);
    int vin;
    int vout;
    int iout;
    int ovp;
    int uvp;
    int hys;
    bps_pkg::fault_t fault;
    status_t s;
    vin = pin_mv(vin_c);
    vout = pin_mv(vout_c);
    iout = pin_mv(iout_c);
    ovp = int'(sup_cfg.vin_over_mv);
    uvp = int'(sup_cfg.vin_under_mv);
    hys = int'(sup_cfg.vin_hysteresis_mv);

    // soft start ends one sample after both references sit on target
    if (running && soft_starting) begin
      if (vref_now >= int'(sup_cfg.voltage_target_mv) &&
          iref_now >= int'(sup_cfg.current_target_ma)) soft_starting = 1'b0;
      if (vref_now < int'(sup_cfg.voltage_target_mv)) vref_now++;
      if (iref_now < int'(sup_cfg.current_target_ma)) iref_now++;
    end

    fault = bps_pkg::FAULT_NONE;
    if (vin > ovp) begin
      ov_latched = 1'b1;
      fault = bps_pkg::FAULT_VIN_OVER;
    end else if (ov_latched && !(vin < ovp - hys)) begin
      fault = bps_pkg::FAULT_VIN_OVER;
    end else begin
      ov_latched = 1'b0;
      if (vin < uvp) begin
        uv_latched = 1'b1;
        fault = bps_pkg::FAULT_VIN_UNDR;
      end else if (uv_latched && !(vin > uvp + hys)) begin
        fault = bps_pkg::FAULT_VIN_UNDR;
      end else begin
        uv_latched = 1'b0;
        if (vout > int'(sup_cfg.vout_over_mv)) vout_run++;
        else vout_run = 0;
        if (vout_run > int'(bps_pkg::VOUT_OVER_LIMIT)) begin
          fault = bps_pkg::FAULT_VOUT_OVR;
        end else if (iout > int'(sup_cfg.iout_over_mv)) begin
          iout_run++;
          if (iout_run > int'(bps_pkg::IOUT_OVER_LIMIT)) fault = bps_pkg::FAULT_IOUT_OVR;
        end else begin
          iout_run = 0;
        end
      end
    end

    // any fault restarts; the input latches survive
    if (fault != bps_pkg::FAULT_NONE) begin
      running = 1'b0;
      soft_starting = 1'b1;
      vref_now = 0;
      iref_now = 0;
      vout_run = 0;
      iout_run = 0;
    end else begin
      running = 1'b1;
    end

    s.oe = running;
    s.vref = vref_now[bps_pkg::REF_W-1:0];
    s.iref = iref_now[bps_pkg::REF_W-1:0];
    s.fault = fault;
    s.ramp_done = !soft_starting;
    s.latch = {uv_latched, ov_latched};
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard: status check first, so a stray status never meets the
  // expectation of a sample accepted on the same edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    preset_t row;
    status_t got;
    status_t want;
    status_t guess;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got.oe = result_ch.output_enable;
        got.vref = result_ch.voltage_ref_mv;
        got.iref = result_ch.current_ref_ma;
        got.fault = bps_pkg::fault_t'(result_ch.fault_code);
        got.ramp_done = result_ch.ramp_done;
        got.latch = result_ch.vin_fault_latched;
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected status transaction: oe=%0b vref=%0d iref=%0d fault=%0d",
                     got.oe, got.vref, got.iref, got.fault);
        end else begin
          want = status_q.pop_front();
          if (got.oe !== want.oe || got.vref !== want.vref || got.iref !== want.iref ||
              got.fault !== want.fault || got.ramp_done !== want.ramp_done ||
              got.latch !== want.latch) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("status mismatch: expected oe=%0b vref=%0d iref=%0d fault=%0d",
                       want.oe, want.vref, want.iref, want.fault,
                       " ramp_done=%0b latch=%0d", want.ramp_done, want.latch);
              $display("                 actual   oe=%0b vref=%0d iref=%0d fault=%0d",
                       got.oe, got.vref, got.iref, got.fault,
                       " ramp_done=%0b latch=%0d", got.ramp_done, got.latch);
            end
          end
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        row = preset_q.pop_front();
        guess = supervise_sample(sample_ch.vin_code, sample_ch.vout_code,
                                 sample_ch.iout_code);
        status_q.push_back(row.preset ? row.want : guess);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // status side: random stall before each transaction
  // ---------------------------------------------------------------------------
  initial begin : drain
    int stall;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = recv_burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // smallest code whose pin voltage is exactly mv
  function automatic logic [bps_pkg::CODE_W-1:0] code_for_mv(int mv);
    int c;
    c = (mv * 4096 + int'(bps_pkg::ADC_FULL_MV) - 1) / int'(bps_pkg::ADC_FULL_MV);
    if (c > 4095) c = 4095;
    return c[bps_pkg::CODE_W-1:0];
  endfunction

  // input voltage that clears both latches and trips neither check
  function automatic logic [bps_pkg::CODE_W-1:0] vin_safe_code();
    int lo;
    int hi;
    lo = int'(sup_cfg.vin_under_mv) + int'(sup_cfg.vin_hysteresis_mv) + 1;
    hi = int'(sup_cfg.vin_over_mv) - int'(sup_cfg.vin_hysteresis_mv) - 1;
    if (hi > 3299) hi = 3299;
    if (lo > hi) return 12'($urandom_range(0, 4095));
    return code_for_mv($urandom_range(lo, hi));
  endfunction

  function automatic logic [bps_pkg::CODE_W-1:0] code_at_most(int th);
    return code_for_mv($urandom_range(0, (th > 3299) ? 3299 : th));
  endfunction

  // unreachable thresholds fall back to any code
  function automatic logic [bps_pkg::CODE_W-1:0] code_above(int th);
    if (th >= 3299) return 12'($urandom_range(0, 4095));
    return code_for_mv($urandom_range(th + 1, 3299));
  endfunction

  // one sample transaction; valid stays up when the next one follows at once
  task automatic send_sample(logic [bps_pkg::CODE_W-1:0] vin,
                             logic [bps_pkg::CODE_W-1:0] vout,
                             logic [bps_pkg::CODE_W-1:0] iout, bit preset,
                             status_t want);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    preset_q.push_back('{preset, want});
    sample_ch.valid <= 1'b1;
    sample_ch.vin_code <= vin;
    sample_ch.vout_code <= vout;
    sample_ch.iout_code <= iout;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // mostly clean samples with the odd output spike, plus input faults and noise
  task automatic run_mix(int n);
    int pick;
    logic [bps_pkg::CODE_W-1:0] vin;
    logic [bps_pkg::CODE_W-1:0] vout;
    logic [bps_pkg::CODE_W-1:0] iout;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        vin = vin_safe_code();
        vout = ($urandom_range(0, 9) == 0) ? code_above(int'(sup_cfg.vout_over_mv))
                                           : code_at_most(int'(sup_cfg.vout_over_mv));
        iout = ($urandom_range(0, 9) == 0) ? code_above(int'(sup_cfg.iout_over_mv))
                                           : code_at_most(int'(sup_cfg.iout_over_mv));
      end else if (pick < 85) begin
        vin = 12'($urandom_range(0, 4095));
        vout = code_at_most(int'(sup_cfg.vout_over_mv));
        iout = code_at_most(int'(sup_cfg.iout_over_mv));
      end else begin
        vin = 12'($urandom_range(0, 4095));
        vout = 12'($urandom_range(0, 4095));
        iout = 12'($urandom_range(0, 4095));
      end
      send_sample(vin, vout, iout, 1'b0, UNTYPED);
    end
  endtask

  // unbroken run with a clean input; each output either held over or under
  task automatic run_steady(int n, bit vout_hot, bit iout_hot);
    logic [bps_pkg::CODE_W-1:0] vout;
    logic [bps_pkg::CODE_W-1:0] iout;
    for (int k = 0; k < n; k++) begin
      vout = vout_hot ? code_above(int'(sup_cfg.vout_over_mv))
                      : code_at_most(int'(sup_cfg.vout_over_mv));
      iout = iout_hot ? code_above(int'(sup_cfg.iout_over_mv))
                      : code_at_most(int'(sup_cfg.iout_over_mv));
      send_sample(vin_safe_code(), vout, iout, 1'b0, UNTYPED);
    end
  endtask

  // drain everything in flight, then pick the idling style of the next phase
  task automatic settle();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (status_q.size() != 0);
    repeat (4) @(posedge clk);
    send_burst = ($urandom_range(0, 3) == 0);
    recv_burst = ($urandom_range(0, 3) == 0);
  endtask

  // apb write of one register followed by a read-back
  task automatic write_reg(bps_pkg::reg_idx_t idx, logic [bps_pkg::DATA_W-1:0] value);
    logic [bps_pkg::DATA_W-1:0] back;
    logic [bps_pkg::DATA_W-1:0] held;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      bps_pkg::REG_VIN_OVER:    sup_cfg.vin_over_mv = value[bps_pkg::MV_W-1:0];
      bps_pkg::REG_VIN_UNDER:   sup_cfg.vin_under_mv = value[bps_pkg::MV_W-1:0];
      bps_pkg::REG_VIN_HYST:    sup_cfg.vin_hysteresis_mv = value[bps_pkg::MV_W-1:0];
      bps_pkg::REG_VOUT_OVER:   sup_cfg.vout_over_mv = value[bps_pkg::MV_W-1:0];
      bps_pkg::REG_IOUT_OVER:   sup_cfg.iout_over_mv = value[bps_pkg::MV_W-1:0];
      bps_pkg::REG_VOLT_TARGET: sup_cfg.voltage_target_mv = value[bps_pkg::REF_W-1:0];
      bps_pkg::REG_CURR_TARGET: sup_cfg.current_target_ma = value[bps_pkg::REF_W-1:0];
      default: ;
    endcase
    held = (idx <= bps_pkg::REG_IOUT_OVER) ? (value & 32'h0000_0FFF)
                                           : (value & 32'h0000_3FFF);
    // read-back: prdata is valid in the access phase
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    back = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (back !== held) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d read-back: expected %0d, actual %0d", idx, held, back);
    end
  endtask

  task automatic load_thresholds(int vo, int vu, int vh, int oo, int io, int vt, int ct);
    write_reg(bps_pkg::REG_VIN_OVER, vo);
    write_reg(bps_pkg::REG_VIN_UNDER, vu);
    write_reg(bps_pkg::REG_VIN_HYST, vh);
    write_reg(bps_pkg::REG_VOUT_OVER, oo);
    write_reg(bps_pkg::REG_IOUT_OVER, io);
    write_reg(bps_pkg::REG_VOLT_TARGET, vt);
    write_reg(bps_pkg::REG_CURR_TARGET, ct);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    sample_ch.valid <= 1'b0;
    sample_ch.vin_code <= '0;
    sample_ch.vout_code <= '0;
    sample_ch.iout_code <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // stimulus table at reset thresholds
    foreach (plan[k])
      send_sample(plan[k].vin, plan[k].vout, plan[k].iout, plan[k].preset, plan[k].want);

    // reset thresholds, random traffic
    settle();
    run_mix(200);

    // widest input window, zero hysteresis, zero output voltage threshold and targets:
    // soft start is done on the first running sample
    settle();
    load_thresholds(3300, 0, 0, 0, 3300, 0, 0);
    run_mix(120);

    // every register at its field maximum: undervoltage can never clear
    settle();
    load_thresholds(4095, 4095, 4095, 4095, 4095, 16383, 16383);
    run_mix(30);

    // small targets: a clean stretch finishes the soft start, then a long
    // output overvoltage run trips on its 201st sample
    settle();
    load_thresholds(3000, 300, 100, 500, 1000, 25, 37);
    run_mix(60);
    run_steady(40, 1'b0, 1'b0);
    run_steady(210, 1'b1, 1'b0);
    run_mix(60);

    // long overcurrent run, the counter climbs well short of its limit
    settle();
    load_thresholds(2500, 600, 50, 3300, 1500, $urandom_range(0, 60),
                    $urandom_range(0, 60));
    run_steady(300, 1'b0, 1'b1);
    run_mix(30);

    // random setting inside the documented ranges
    settle();
    load_thresholds($urandom_range(0, 3300), $urandom_range(0, 3300),
                    $urandom_range(0, 400), $urandom_range(0, 3300),
                    $urandom_range(0, 3300), $urandom_range(0, 15000),
                    $urandom_range(0, 10000));
    run_mix(150);

    // reset thresholds without hysteresis, tiny targets
    settle();
    load_thresholds(int'(bps_pkg::RST_VIN_OVER), int'(bps_pkg::RST_VIN_UNDER), 0,
                    int'(bps_pkg::RST_VOUT_OVER), int'(bps_pkg::RST_IOUT_OVER), 3, 2);
    run_steady(20, 1'b0, 1'b0);
    run_mix(20);

    // wait out everything still in flight
    settle();
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
